/* src/assert_macros.svh */
// Assertion macros used by the top RTL file of the decimal conversion block.
// Each macro checks on the rising clock edge and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* src/b2da_pkg.sv */
// Package for the binary to decimal ASCII converter.
// Holds widths, the ASCII offset and the digit count function; no dependencies.
`default_nettype none

package b2da_pkg;

  localparam int ValueWidthDefault = 32;
  localparam int DigitWidth = 4;
  localparam int CharWidth = 6;
  localparam logic [CharWidth-1:0] AsciiZero = 6'd48;
  localparam logic [DigitWidth-1:0] MaxDigit = 4'd9;

  typedef logic [DigitWidth-1:0] digit_t;
  typedef logic [CharWidth-1:0] char_t;

  // Decimal digits needed for the largest value of the given bit width.
  function automatic int num_digits(input int width);
    return ((width * 1233) >>> 12) + 1;
  endfunction

endpackage

`default_nettype wire

/* src/b2da_in_if.sv */
// Input channel of the converter: one binary value per item.
// Depends on no package; the value width is a parameter.
`default_nettype none

interface b2da_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

/* src/b2da_out_if.sv */
// Output channel of the converter: one ASCII digit per item.
// Depends on b2da_pkg for the character type.
`default_nettype none

interface b2da_out_if;
  import b2da_pkg::*;

  logic  valid;
  logic  ready;
  char_t digit_char;
  logic  last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

/* src/b2da_dabble.sv */
// Bit-serial binary to BCD converter using shift and add-three, one bit per cycle.
// Depends on b2da_pkg and b2da_in_if.
`default_nettype none

module b2da_dabble #(
  parameter int VALUE_WIDTH = b2da_pkg::ValueWidthDefault
) (
  input  logic clk,
  input  logic rst,
  b2da_in_if.sink din,
  output logic bcd_valid,
  input  logic bcd_ready,
  output logic [b2da_pkg::num_digits(VALUE_WIDTH)*b2da_pkg::DigitWidth-1:0] bcd
);
  import b2da_pkg::*;

  localparam int NumDigits = num_digits(VALUE_WIDTH);
  localparam int BcdWidth = NumDigits * DigitWidth;
  localparam int CntWidth = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic [VALUE_WIDTH-1:0] bin;
  logic [CntWidth-1:0]    cnt;
  logic [BcdWidth-1:0]    adj;
  logic                   accept;

  assign din.ready = !busy && !bcd_valid;
  assign accept = din.valid && din.ready;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[i*DigitWidth +: DigitWidth] >= 4'd5) begin
        adj[i*DigitWidth +: DigitWidth] = bcd[i*DigitWidth +: DigitWidth] + 4'd3;
      end else begin
        adj[i*DigitWidth +: DigitWidth] = bcd[i*DigitWidth +: DigitWidth];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bcd_valid <= 1'b0;
    end else begin
      if (bcd_valid && bcd_ready) begin
        bcd_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (busy && cnt == CntWidth'(1)) begin
        busy      <= 1'b0;
        bcd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin <= din.value;
      bcd <= '0;
      cnt <= CntWidth'(VALUE_WIDTH);
    end else if (busy) begin
      bcd <= {adj[BcdWidth-2:0], bin[VALUE_WIDTH-1]};
      bin <= {bin[VALUE_WIDTH-2:0], 1'b0};
      cnt <= cnt - CntWidth'(1);
    end
  end

endmodule

`default_nettype wire

/* src/b2da_emit.sv */
// Digit shifter: sends BCD digits most significant first as ASCII, skipping leading zeros.
// Depends on b2da_pkg and b2da_out_if.
`default_nettype none

module b2da_emit #(
  parameter int VALUE_WIDTH = b2da_pkg::ValueWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic bcd_valid,
  output logic bcd_ready,
  input  logic [b2da_pkg::num_digits(VALUE_WIDTH)*b2da_pkg::DigitWidth-1:0] bcd,
  b2da_out_if.source dout
);
  import b2da_pkg::*;

  localparam int NumDigits = num_digits(VALUE_WIDTH);
  localparam int BcdWidth = NumDigits * DigitWidth;
  localparam int LeftWidth = $clog2(NumDigits + 1);

  logic [BcdWidth-1:0]  sr;
  logic [LeftWidth-1:0] left;
  logic                 started;
  logic                 out_valid;
  char_t                out_char;
  logic                 out_last;
  digit_t               top;
  logic                 is_last;
  logic                 can_step;
  logic                 emit;
  logic                 load;

  assign top = sr[BcdWidth-1 -: DigitWidth];
  assign is_last = left == LeftWidth'(1);
  assign can_step = (left != '0) && (!out_valid || dout.ready);
  assign emit = (top != '0) || started || is_last;
  assign bcd_ready = left == '0;
  assign load = bcd_valid && bcd_ready;

  assign dout.valid = out_valid;
  assign dout.digit_char = out_char;
  assign dout.last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      left      <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && dout.ready) begin
        out_valid <= 1'b0;
      end
      if (can_step) begin
        left <= left - LeftWidth'(1);
        if (emit) begin
          out_valid <= 1'b1;
          started   <= 1'b1;
        end
      end
      if (load) begin
        left    <= LeftWidth'(NumDigits);
        started <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sr <= bcd;
    end else if (can_step) begin
      sr <= sr << DigitWidth;
    end
    if (can_step && emit) begin
      out_char <= CharWidth'(top) + AsciiZero;
      out_last <= is_last;
    end
  end

endmodule

`default_nettype wire

/* src/binary_to_decimal_ascii.sv */
// An accepted value is converted bit-serially by the shift-and-add-three converter; the
// digit shifter then skips leading zero digits and registers one ASCII digit per step,
// stepping on when the previous digit is taken. A new value is accepted only after the
// last BCD result has passed to the digit shifter, so digit output overlaps the next conversion.
// Reset: synchronous, active high, clears the control state; data registers are not reset.
`default_nettype none

module binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = b2da_pkg::ValueWidthDefault
) (
  input  logic clk,
  input  logic rst,
  b2da_in_if.sink din,
  b2da_out_if.source dout
);
  import b2da_pkg::*;
  `include "assert_macros.svh"

  localparam int BcdWidth = num_digits(VALUE_WIDTH) * DigitWidth;

  logic                bcd_valid;
  logic                bcd_ready;
  logic [BcdWidth-1:0] bcd;
  logic                char_ok;

  b2da_dabble #(.VALUE_WIDTH(VALUE_WIDTH)) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .bcd_valid (bcd_valid),
    .bcd_ready (bcd_ready),
    .bcd       (bcd)
  );

  b2da_emit #(.VALUE_WIDTH(VALUE_WIDTH)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .bcd_valid (bcd_valid),
    .bcd_ready (bcd_ready),
    .bcd       (bcd),
    .dout      (dout)
  );

  assign char_ok = (dout.digit_char >= AsciiZero) &&
                   (dout.digit_char <= AsciiZero + CharWidth'(MaxDigit));

  `ASSERT_NEXT(a_bcd_hold, clk, rst, bcd_valid && !bcd_ready, bcd_valid && $stable(bcd))
  `ASSERT_IMPLIES(a_no_accept_pending, clk, rst, din.valid && din.ready, !bcd_valid)
  `ASSERT_IMPLIES(a_char_range, clk, rst, dout.valid, char_ok)

endmodule

`default_nettype wire

/* sim/binary_to_decimal_ascii_tb.sv */
// Testbench for binary_to_decimal_ascii: drives binary values in bursts and checks every
// ASCII digit and its last flag against a decimal predictor kept in the bench.
// Depends on b2da_pkg, b2da_in_if, b2da_out_if and the binary_to_decimal_ascii RTL.
`timescale 1ns / 100ps
`default_nettype none

module binary_to_decimal_ascii_tb;
  import b2da_pkg::*;

  localparam int ValueWidth = 32;
  localparam int DecimalBase = 10;
  localparam int MaxDigits = 10;
  localparam int RandomItems = 410;
  localparam int DrainCycles = 4 * (ValueWidth + 2);

  localparam logic [ValueWidth-1:0] CornerValues [22] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
    32'd99999, 32'd100000, 32'd9999999, 32'd10000000, 32'd999999999,
    32'd1000000000, 32'd1234567890, 32'd4000000000, 32'h7FFFFFFF, 32'h80000000,
    32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFE, 32'hFFFFFFFF
  };

  typedef struct packed {
    char_t digit_char;
    logic  last;
  } digit_item_t;

  typedef enum logic [1:0] {
    RecvSteady,
    RecvChoppy,
    RecvSlow
  } recv_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  b2da_in_if #(.VALUE_WIDTH(ValueWidth)) value_ch ();
  b2da_out_if digit_ch ();

  binary_to_decimal_ascii #(.VALUE_WIDTH(ValueWidth)) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (value_ch),
    .dout (digit_ch)
  );

  logic [ValueWidth-1:0] pending_values[$];
  digit_item_t expected_digits[$];
  int total_items = 0;
  int accepted_count = 0;
  int error_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int recv_left = 0;
  recv_mode_t recv_mode = RecvSteady;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Splits a value into decimal digits and queues them most significant first.
  function automatic void predict_digits(input logic [ValueWidth-1:0] value);
    int unsigned rest;
    int unsigned digits[MaxDigits];
    int count;
    digit_item_t item;
    rest = value;
    count = 0;
    do begin
      digits[count] = rest % DecimalBase;
      rest = rest / DecimalBase;
      count++;
    end while (rest != 0 && count < MaxDigits);
    for (int k = count - 1; k >= 0; k--) begin
      item.digit_char = AsciiZero + char_t'(digits[k]);
      item.last = (k == 0);
      expected_digits.push_back(item);
    end
  endfunction

  function automatic logic [ValueWidth-1:0] value_with_digits(input int num);
    longint unsigned lo;
    longint unsigned hi;
    lo = 1;
    for (int k = 1; k < num; k++) begin
      lo = lo * DecimalBase;
    end
    hi = lo * DecimalBase - 1;
    if (num == 1) begin
      lo = 0;
    end
    if (hi > 64'hFFFFFFFF) begin
      hi = 64'hFFFFFFFF;
    end
    return $urandom_range(int'(hi), int'(lo));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      value_ch.valid <= 1'b0;
    end else begin
      if (value_ch.valid && value_ch.ready) begin
        predict_digits(value_ch.value);
        accepted_count++;
      end
      if (!value_ch.valid || value_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          value_ch.valid <= 1'b0;
        end else if (pending_values.size() > 0) begin
          value_ch.value <= pending_values.pop_front();
          value_ch.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
          end
        end else begin
          value_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      digit_ch.ready <= 1'b0;
    end else begin
      if (digit_ch.valid && digit_ch.ready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit: expected none, got char %0d last %0b",
                   $time, digit_ch.digit_char, digit_ch.last);
          error_count++;
        end else begin
          digit_item_t want;
          want = expected_digits.pop_front();
          if (digit_ch.digit_char !== want.digit_char || digit_ch.last !== want.last) begin
            $display("%0t: digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                     $time, want.digit_char, want.last, digit_ch.digit_char,
                     digit_ch.last);
            error_count++;
          end
        end
      end
      if (recv_left == 0) begin
        recv_mode = recv_mode_t'($urandom_range(0, 2));
        recv_left = $urandom_range(20, 200);
      end else begin
        recv_left--;
      end
      case (recv_mode)
        RecvSteady: begin
          digit_ch.ready <= 1'b1;
        end
        RecvChoppy: begin
          digit_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          digit_ch.ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  initial begin
    value_ch.valid = 1'b0;
    value_ch.value = '0;
    digit_ch.ready = 1'b0;
    foreach (CornerValues[i]) begin
      pending_values.push_back(CornerValues[i]);
    end
    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        pending_values.push_back($urandom);
      end else begin
        pending_values.push_back(value_with_digits($urandom_range(1, MaxDigits)));
      end
    end
    total_items = pending_values.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (accepted_count < total_items) @(posedge clk);
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && expected_digits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
